[hdl/mnd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mnd_pkg
// Shared types, widths, register indexes and note tables of the melody note
// decoder.
// ----------------------------------------------------------------------------
package mnd_pkg;

	localparam int TONE_W  = 8;
	localparam int LEN_W   = 8;
	localparam int FREQ_W  = 13;
	localparam int MS_W    = 16;
	localparam int SEMI_W  = 4;
	localparam int EXPO_W  = 3;
	localparam int TRANS_W = 4;
	localparam int OCT_W   = 3;
	localparam int NUMER_W = 3;
	localparam int HZ_W    = 9;
	localparam int BASE_W  = HZ_W + 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WHOLE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMER     = 2'd3;

	localparam logic [MS_W-1:0]    WHOLE_RESET = 16'd1600;
	localparam logic [NUMER_W-1:0] NUMER_RESET = 3'd4;
	localparam logic [FREQ_W-1:0]  FREQ_MAX    = 13'h1FFF;
	localparam logic [MS_W-1:0]    MS_MAX      = 16'hFFFF;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		RANGE_LOW,
		RANGE_MID,
		RANGE_HIGH
	} range_t;

	typedef enum logic [1:0] {
		EFF_NORMAL,
		EFF_LEGATO,
		EFF_STACCATO
	} effect_t;

	typedef struct packed {
		logic              rest;
		logic [SEMI_W-1:0] semi;
		range_t            range;
		logic [EXPO_W-1:0] expo;
		effect_t           effect;
		logic              dotted;
	} note_item_t;

	typedef struct packed {
		logic [TRANS_W-1:0] transpose;
		logic [OCT_W-1:0]   octave;
		logic [MS_W-1:0]    whole_ms;
		logic [NUMER_W-1:0] numer;
	} cfg_t;

	function automatic logic [HZ_W-1:0] semitone_hz(input logic [SEMI_W-1:0] pos);
		logic [HZ_W-1:0] hz;
		case (pos)
			4'd0:    hz = 9'd262;
			4'd1:    hz = 9'd277;
			4'd2:    hz = 9'd294;
			4'd3:    hz = 9'd311;
			4'd4:    hz = 9'd330;
			4'd5:    hz = 9'd349;
			4'd6:    hz = 9'd369;
			4'd7:    hz = 9'd392;
			4'd8:    hz = 9'd415;
			4'd9:    hz = 9'd440;
			4'd10:   hz = 9'd466;
			default: hz = 9'd494;
		endcase
		return hz;
	endfunction

	function automatic logic [SEMI_W-1:0] note_to_semi(input logic [2:0] note);
		logic [SEMI_W-1:0] s;
		case (note)
			3'd2:    s = 4'd2;
			3'd3:    s = 4'd4;
			3'd4:    s = 4'd5;
			3'd5:    s = 4'd7;
			3'd6:    s = 4'd9;
			3'd7:    s = 4'd11;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[hdl/mnd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mnd_front
// Accepts note codes, splits them into decimal digits and classifies them
// into a decoded note item held in one register.
// ----------------------------------------------------------------------------
module mnd_front import mnd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              note_valid,
	output logic                   note_stall,
	input  wire logic [TONE_W-1:0] tone_code,
	input  wire logic [LEN_W-1:0]  length_code,
	output logic                   item_valid,
	output note_item_t             item,
	input  wire logic              item_full
);

	typedef struct packed {
		logic [1:0] hund;
		logic [3:0] tens;
		logic [3:0] units;
	} digits_t;

	function automatic digits_t split_digits(input logic [7:0] code);
		digits_t    d;
		logic [7:0] rem8;
		logic [6:0] rem;
		logic [14:0] prod;
		if (code >= 8'd200) begin
			d.hund = 2'd2;
			rem8   = code - 8'd200;
		end else if (code >= 8'd100) begin
			d.hund = 2'd1;
			rem8   = code - 8'd100;
		end else begin
			d.hund = 2'd0;
			rem8   = code;
		end
		rem     = rem8[6:0];
		prod    = 15'(rem) * 15'd205;
		d.tens  = prod[14:11];
		d.units = 4'(rem - 7'(d.tens) * 7'd10);
		return d;
	endfunction

	digits_t           tone_d;
	digits_t           len_d;
	note_item_t        dec;
	logic [2:0]        note_sat;
	logic [SEMI_W:0]   semi_sum;
	logic              adv;

	always_comb begin
		tone_d   = split_digits(tone_code);
		len_d    = split_digits(length_code);
		note_sat = (tone_d.units > 4'd7) ? 3'd7 : tone_d.units[2:0];
		semi_sum = (SEMI_W+1)'(note_to_semi(note_sat)) + (SEMI_W+1)'(tone_d.hund);

		dec.rest = (tone_d.units == 4'd0);
		dec.semi = (semi_sum > 5'd11) ? 4'd11 : semi_sum[SEMI_W-1:0];
		case (tone_d.tens)
			4'd1:    dec.range = RANGE_LOW;
			4'd3:    dec.range = RANGE_HIGH;
			default: dec.range = RANGE_MID;
		endcase
		dec.expo = (len_d.units > 4'd6) ? 3'd6 : len_d.units[2:0];
		case (len_d.tens)
			4'd0:    dec.effect = EFF_NORMAL;
			4'd1:    dec.effect = EFF_LEGATO;
			default: dec.effect = EFF_STACCATO;
		endcase
		dec.dotted = (len_d.hund == 2'd1);
	end

	assign adv        = !item_valid || !item_full;
	assign note_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (adv) begin
			item_valid <= note_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && note_valid) begin
			item <= dec;
		end
	end

endmodule
`default_nettype wire

[hdl/mnd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mnd_queue
// Short queue of decoded note items between the front and the back.
// ----------------------------------------------------------------------------
module mnd_queue import mnd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	input  wire note_item_t  push_item,
	output logic             full,
	output logic             pop_valid,
	output note_item_t       pop_item,
	input  wire logic        pop_ready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	note_item_t       slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign full      = (count_q == CNT_FULL);
	assign pop_valid = (count_q != '0);
	assign pop_item  = slot_q[rd_ptr_q];
	assign push      = push_valid && !full;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef ASSERT_OFF
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count exceeds depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");
`endif

endmodule
`default_nettype wire

[hdl/mnd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mnd_back
// Four-stage pipeline that turns a decoded note item into its frequency,
// sounding time and silent time. The last stage is the output register.
// ----------------------------------------------------------------------------
module mnd_back import mnd_pkg::*; #(
	parameter int SPACE_DENOM = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	input  wire note_item_t        in_item,
	output logic                   in_ready,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [FREQ_W-1:0]      freq_hz,
	output logic [MS_W-1:0]        sound_ms,
	output logic [MS_W-1:0]        silence_ms
);

	localparam int PROD_W  = MS_W + NUMER_W;
	localparam int RECIP_K = PROD_W;
	localparam int RECIP_W = RECIP_K + 1;
	localparam int QP_W    = PROD_W + RECIP_W;
	localparam int DEN_W   = $clog2(SPACE_DENOM + 1);
	localparam int QD_W    = PROD_W + DEN_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_K) / SPACE_DENOM);
	localparam logic [PROD_W-1:0]  DENOM = PROD_W'(SPACE_DENOM);

	logic en;
	assign en       = !(result_valid && result_stall);
	assign in_ready = en;

	// Stage 1: transposed base frequency and note time.
	logic [SEMI_W:0]    pos_sum;
	logic [SEMI_W-1:0]  pos;
	logic [1:0]         octs;
	logic [BASE_W-1:0]  base;
	logic [MS_W-1:0]    nl_shift;
	logic [MS_W:0]      nl_dot;
	logic [MS_W-1:0]    dur_ms;

	always_comb begin
		pos_sum = (SEMI_W+1)'(in_item.semi) + (SEMI_W+1)'(cfg.transpose);
		if (pos_sum >= 5'd24) begin
			pos  = SEMI_W'(pos_sum - 5'd24);
			octs = 2'd2;
		end else if (pos_sum >= 5'd12) begin
			pos  = SEMI_W'(pos_sum - 5'd12);
			octs = 2'd1;
		end else begin
			pos  = pos_sum[SEMI_W-1:0];
			octs = 2'd0;
		end
		base     = BASE_W'(semitone_hz(pos)) << octs;
		nl_shift = cfg.whole_ms >> in_item.expo;
		nl_dot   = (MS_W+1)'(nl_shift)
			+ (in_item.dotted ? (MS_W+1)'(nl_shift >> 1) : '0);
		dur_ms   = nl_dot[MS_W] ? MS_MAX : nl_dot[MS_W-1:0];
	end

	logic              valid_s1;
	logic [BASE_W-1:0] base_s1;
	logic [MS_W-1:0]   dur_ms_s1;
	logic              rest_s1;
	range_t            range_s1;
	effect_t           effect_s1;

	// Stage 2: octave and range shifts, sounding-fraction product.
	logic signed [OCT_W-1:0] oct;
	logic [OCT_W-1:0]        oct_amt;
	logic [BASE_W+2:0]       f_oct;
	logic [BASE_W+3:0]       f_rng;
	logic [FREQ_W-1:0]       freq;
	logic [PROD_W-1:0]       prod;

	always_comb begin
		oct     = $signed(cfg.octave);
		oct_amt = OCT_W'(-oct);
		if (oct < 0) begin
			f_oct = (BASE_W+3)'(base_s1) >> oct_amt;
		end else begin
			f_oct = (BASE_W+3)'(base_s1) << cfg.octave[1:0];
		end
		case (range_s1)
			RANGE_LOW:  f_rng = (BASE_W+4)'(f_oct) >> 1;
			RANGE_HIGH: f_rng = (BASE_W+4)'(f_oct) << 1;
			default:    f_rng = (BASE_W+4)'(f_oct);
		endcase
		if (rest_s1) begin
			freq = '0;
		end else if (f_rng > (BASE_W+4)'(FREQ_MAX)) begin
			freq = FREQ_MAX;
		end else begin
			freq = f_rng[FREQ_W-1:0];
		end
		prod = PROD_W'(dur_ms_s1) * PROD_W'(cfg.numer);
	end

	logic              valid_s2;
	logic [FREQ_W-1:0] freq_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [MS_W-1:0]   dur_ms_s2;
	logic              rest_s2;
	effect_t           effect_s2;

	// Stage 3: quotient estimate by reciprocal multiplication.
	logic [QP_W-1:0]   qprod;
	assign qprod = QP_W'(prod_s2) * QP_W'(RECIP);

	logic              valid_s3;
	logic [PROD_W-1:0] q0_s3;
	logic [FREQ_W-1:0] freq_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [MS_W-1:0]   dur_ms_s3;
	logic              rest_s3;
	effect_t           effect_s3;

	// Stage 4: quotient correction and the split into sound and silence.
	logic [PROD_W-1:0] rem;
	logic [PROD_W-1:0] q;
	logic [MS_W-1:0]   norm;
	logic [MS_W-1:0]   snd;

	always_comb begin
		rem  = prod_s3 - PROD_W'(QD_W'(q0_s3) * QD_W'(SPACE_DENOM));
		q    = q0_s3 + ((rem >= DENOM) ? PROD_W'(1) : PROD_W'(0));
		norm = (q > PROD_W'(dur_ms_s3)) ? dur_ms_s3 : q[MS_W-1:0];
		case (effect_s3)
			EFF_NORMAL: snd = norm;
			EFF_LEGATO: snd = dur_ms_s3;
			default:    snd = dur_ms_s3 >> 1;
		endcase
		if (rest_s3) begin
			snd = '0;
		end
	end

	logic              valid_s4;
	logic [FREQ_W-1:0] freq_s4;
	logic [MS_W-1:0]   sound_s4;
	logic [MS_W-1:0]   silence_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1     <= base;
			dur_ms_s1   <= dur_ms;
			rest_s1     <= in_item.rest;
			range_s1    <= in_item.range;
			effect_s1   <= in_item.effect;

			freq_s2     <= freq;
			prod_s2     <= prod;
			dur_ms_s2   <= dur_ms_s1;
			rest_s2     <= rest_s1;
			effect_s2   <= effect_s1;

			q0_s3       <= qprod[RECIP_K +: PROD_W];
			freq_s3     <= freq_s2;
			prod_s3     <= prod_s2;
			dur_ms_s3   <= dur_ms_s2;
			rest_s3     <= rest_s2;
			effect_s3   <= effect_s2;

			freq_s4     <= freq_s3;
			sound_s4    <= snd;
			silence_s4  <= dur_ms_s3 - snd;
		end
	end

	assign result_valid = valid_s4;
	assign freq_hz      = freq_s4;
	assign sound_ms     = sound_s4;
	assign silence_ms   = silence_s4;

endmodule
`default_nettype wire

[hdl/melody_note_decoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// melody_note_decoder_core
// Decodes note codes into tone frequency, sounding time and silent time.
//
//   Channel   Handshake                Payload
//   note      note_valid / note_stall  tone_code, length_code
//   result    result_valid / result_stall  freq_hz, sound_ms, silence_ms
//   cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One note item is accepted every cycle while note_stall is low; result_valid
// rises once it has passed the front register, the queue and four back stages.
// The back pipeline length is set by the reciprocal divide and its fix-up.
// Reset clears all valid flags and loads the configuration defaults.
// A result stall holds the back pipeline; the two-entry queue and the front
// register then fill before note_stall rises.
// ----------------------------------------------------------------------------
module melody_note_decoder_core import mnd_pkg::*; #(
	parameter int SPACE_DENOM = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  note_valid,
	output logic                       note_stall,
	input  wire logic [TONE_W-1:0]     tone_code,
	input  wire logic [LEN_W-1:0]      length_code,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [FREQ_W-1:0]          freq_hz,
	output logic [MS_W-1:0]            sound_ms,
	output logic [MS_W-1:0]            silence_ms,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [TRANS_W-1:0] transpose_q;
	logic [OCT_W-1:0]   octave_q;
	logic [MS_W-1:0]    whole_q;
	logic [NUMER_W-1:0] numer_q;
	cfg_t               cfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transpose_q <= '0;
			octave_q    <= '0;
			whole_q     <= WHOLE_RESET;
			numer_q     <= NUMER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TRANSPOSE: transpose_q <= cfg_data[TRANS_W-1:0];
				CFG_OCTAVE:    octave_q    <= cfg_data[OCT_W-1:0];
				CFG_WHOLE:     whole_q     <= cfg_data[MS_W-1:0];
				CFG_NUMER:     numer_q     <= cfg_data[NUMER_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		cfg.transpose = transpose_q;
		cfg.octave    = octave_q;
		cfg.whole_ms  = whole_q;
		cfg.numer     = numer_q;
	end

	logic       front_valid;
	note_item_t front_item;
	logic       queue_full;
	logic       queue_valid;
	note_item_t queue_item;
	logic       back_ready;

	mnd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.note_valid  (note_valid),
		.note_stall  (note_stall),
		.tone_code   (tone_code),
		.length_code (length_code),
		.item_valid  (front_valid),
		.item        (front_item),
		.item_full   (queue_full)
	);

	mnd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_item  (front_item),
		.full       (queue_full),
		.pop_valid  (queue_valid),
		.pop_item   (queue_item),
		.pop_ready  (back_ready)
	);

	mnd_back #(
		.SPACE_DENOM (SPACE_DENOM)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (queue_valid),
		.in_item      (queue_item),
		.in_ready     (back_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.freq_hz      (freq_hz),
		.sound_ms     (sound_ms),
		.silence_ms   (silence_ms)
	);

endmodule
`default_nettype wire
